@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the cycle after the trigger
`define CHECK_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("check failed");

// condition must hold in the cycle of the trigger
`define CHECK_NOW(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("check failed");

`endif

@@ design/gks_pkg.sv @@
`default_nettype none
package gks_pkg;

	typedef struct packed {
		logic signed [15:0] feature;
		logic signed [15:0] coefficient;
		logic               last_of_point;
		logic               last_of_set;
	} item_t;

	typedef struct packed {
		logic signed [39:0] kernel_sum;
		logic [5:0]         point_index;
		logic               last;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ALIGN,
		ST_ROW,
		ST_DIST,
		ST_OUT
	} state_t;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [19:0] ARG_LIMIT = 20'd786432;
	localparam logic [16:0] K_SAT     = 17'd65535;

	// 2^(-k/16) in Q.16
	function automatic logic [16:0] pow2_neg(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62757;
			5'd2:    v = 17'd60097;
			5'd3:    v = 17'd57549;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52773;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			5'd16:   v = 17'd32768;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ design/gaussian_kernel_sum.sv @@
// load: one feature element per cycle; the block stalls from the closing element of a set
// compute: per pair j > i one shared distance unit, plus one ring rotation per position,
// MAX_POINTS positions per row, after MAX_POINTS - n alignment steps
// results: one per cycle unless result_stall holds them, from the head of the cell ring, through an output register
// reset: arst_n clears counters, state and output valid; stores hold data until written
`default_nettype none
module gaussian_kernel_sum #(
	parameter int MAX_POINTS = 64,
	parameter int DIMENSION  = 100
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire gks_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output gks_pkg::result_t      result
);

	import gks_pkg::*;

	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int LW    = $clog2(DIMENSION + 1);
	localparam int DW    = $clog2(DIMENSION + 7);
	localparam int DEPTH = MAX_POINTS * DIMENSION;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = 32 + LW;

	state_t state_q, state_d;
	logic [CW-1:0] pc_q, pc_d;
	logic [LW-1:0] ec_q, ec_d;
	logic          drop_q, drop_d;
	logic [CW-1:0] n_q, n_d;
	logic          ovf_q, ovf_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] p_q, p_d;
	logic [DW-1:0] dcnt_q, dcnt_d;
	logic          out_valid_q, out_valid_d;
	result_t       out_q, out_d;

	logic signed [15:0] ci_q, ci_d;
	logic [LW-1:0]      leni_q, leni_d;
	logic signed [39:0] acc_q, acc_d;

	logic               in_xfer;
	logic               full;
	logic               end_point;
	logic               ec_lt;
	logic [LW-1:0]      ec_inc;
	logic               step;
	logic               r2_clr;
	logic               load_tail;
	logic signed [39:0] add_val;
	cell_ctrl_t         ring_ctrl;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic [15:0]   rd_data_a;
	logic [15:0]   rd_data_b;
	logic          issue;

	logic               mask_i_s1;
	logic               mask_p_s1;
	logic signed [16:0] xa;
	logic signed [16:0] xb;
	logic signed [16:0] diff;
	logic signed [33:0] sq;
	logic [31:0]        sq_s2;
	logic [RW-1:0]      r2_q;
	logic [15:0]        k;
	logic signed [32:0] prod_i_s6;
	logic signed [32:0] prod_p_s6;
	logic signed [17:0] term_i;
	logic signed [17:0] term_p;

	logic signed [15:0] cell_coef [MAX_POINTS];
	logic [LW-1:0]      cell_len  [MAX_POINTS];
	logic signed [39:0] cell_sum  [MAX_POINTS];
	logic signed [15:0] nxt_coef  [MAX_POINTS];
	logic [LW-1:0]      nxt_len   [MAX_POINTS];
	logic signed [39:0] nxt_sum   [MAX_POINTS];

	assign item_stall = (state_q != ST_LOAD);
	assign in_xfer    = item_valid && !item_stall;
	assign full       = (pc_q >= CW'(MAX_POINTS));
	assign end_point  = item.last_of_point || item.last_of_set;
	assign ec_lt      = (ec_q < LW'(DIMENSION));
	assign ec_inc     = ec_lt ? LW'(ec_q + 1'b1) : ec_q;

	assign wr_en   = in_xfer && !full && ec_lt;
	assign wr_addr = AW'(int'(pc_q) * DIMENSION + int'(ec_q));

	assign issue     = (state_q == ST_DIST) && (dcnt_q < DW'(DIMENSION));
	assign rd_addr_a = AW'(int'(i_q) * DIMENSION + int'(dcnt_q));
	assign rd_addr_b = AW'(int'(p_q) * DIMENSION + int'(dcnt_q));

	assign term_i = prod_i_s6[32:15];
	assign term_p = prod_p_s6[32:15];

	always_comb begin
		state_d     = state_q;
		pc_d        = pc_q;
		ec_d        = ec_q;
		drop_d      = drop_q;
		n_d         = n_q;
		ovf_d       = ovf_q;
		i_d         = i_q;
		p_d         = p_q;
		dcnt_d      = dcnt_q;
		ci_d        = ci_q;
		leni_d      = leni_q;
		acc_d       = acc_q;
		out_valid_d = out_valid_q && result_stall;
		out_d       = out_q;
		step        = 1'b0;
		r2_clr      = 1'b0;
		load_tail   = 1'b0;
		add_val     = '0;
		ring_ctrl   = '0;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer) begin
					ec_d = ec_inc;
					if (end_point) begin
						ec_d = '0;
						if (full) begin
							drop_d = 1'b1;
						end else begin
							ring_ctrl.shift = 1'b1;
							load_tail       = 1'b1;
							pc_d            = CW'(pc_q + 1'b1);
						end
					end
					if (item.last_of_set) begin
						n_d             = full ? pc_q : CW'(pc_q + 1'b1);
						ovf_d           = drop_q || full;
						pc_d            = '0;
						ec_d            = '0;
						drop_d          = 1'b0;
						i_d             = '0;
						p_d             = '0;
						ring_ctrl.clear = 1'b1;
						state_d         = ST_ALIGN;
					end
				end
			end
			ST_ALIGN: begin
				if (n_q == '0) begin
					state_d = ST_LOAD;
				end else if (p_q == CW'(CW'(MAX_POINTS) - n_q)) begin
					p_d     = '0;
					state_d = ST_ROW;
				end else begin
					ring_ctrl.shift = 1'b1;
					p_d             = CW'(p_q + 1'b1);
				end
			end
			ST_ROW: begin
				if (p_q > i_q && p_q < n_q) begin
					dcnt_d  = '0;
					r2_clr  = 1'b1;
					state_d = ST_DIST;
				end else begin
					if (i_q != '0 && p_q == CW'(i_q - 1'b1)) begin
						add_val = acc_q;
					end else if (p_q == i_q) begin
						add_val = {{23{cell_coef[0][15]}}, cell_coef[0], 1'b0};
						ci_d    = cell_coef[0];
						leni_d  = cell_len[0];
						acc_d   = '0;
					end
					step = 1'b1;
				end
			end
			ST_DIST: begin
				dcnt_d = DW'(dcnt_q + 1'b1);
				if (dcnt_q == DW'(DIMENSION + 6)) begin
					add_val = 40'(term_i);
					acc_d   = acc_q + 40'(term_p);
					step    = 1'b1;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !result_stall) begin
					out_valid_d       = 1'b1;
					out_d.kernel_sum  = cell_sum[0];
					out_d.point_index = 6'(p_q);
					out_d.last        = (p_q == CW'(n_q - 1'b1));
					out_d.overflow    = ovf_q;
					ring_ctrl.shift   = 1'b1;
					if (p_q == CW'(n_q - 1'b1)) begin
						p_d     = '0;
						state_d = ST_LOAD;
					end else begin
						p_d = CW'(p_q + 1'b1);
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
		if (step) begin
			ring_ctrl.shift = 1'b1;
			state_d         = ST_ROW;
			if (p_q == CW'(MAX_POINTS - 1)) begin
				p_d = '0;
				if (i_q == CW'(n_q - 1'b1)) begin
					state_d = ST_OUT;
				end else begin
					i_d = CW'(i_q + 1'b1);
				end
			end else begin
				p_d = CW'(p_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			pc_q        <= '0;
			ec_q        <= '0;
			drop_q      <= 1'b0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			p_q         <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pc_q        <= pc_d;
			ec_q        <= ec_d;
			drop_q      <= drop_d;
			n_q         <= n_d;
			ovf_q       <= ovf_d;
			i_q         <= i_d;
			p_q         <= p_d;
			dcnt_q      <= dcnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q  <= out_d;
		ci_q   <= ci_d;
		leni_q <= leni_d;
		acc_q  <= acc_d;
	end

	gks_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_feature_ram (
		.clk,
		.wr_en,
		.wr_addr,
		.wr_data  (item.feature),
		.rd_addr_a,
		.rd_data_a,
		.rd_addr_b,
		.rd_data_b
	);

	// distance unit: missing elements of a short point count as zero
	always_ff @(posedge clk) begin
		mask_i_s1 <= issue && (dcnt_q < leni_q);
		mask_p_s1 <= issue && (dcnt_q < cell_len[0]);
	end

	assign xa   = mask_i_s1 ? 17'($signed(rd_data_a)) : '0;
	assign xb   = mask_p_s1 ? 17'($signed(rd_data_b)) : '0;
	assign diff = xa - xb;
	assign sq   = diff * diff;

	always_ff @(posedge clk) begin
		sq_s2 <= sq[31:0];
		if (r2_clr) begin
			r2_q <= '0;
		end else begin
			r2_q <= r2_q + RW'(sq_s2);
		end
	end

	gks_kernel #(
		.R_W(RW)
	) u_kernel (
		.clk,
		.r2 (r2_q),
		.k
	);

	always_ff @(posedge clk) begin
		prod_i_s6 <= $signed({1'b0, k}) * ci_q;
		prod_p_s6 <= $signed({1'b0, k}) * cell_coef[0];
	end

	// ring of point cells, head at cell 0, new points enter at the tail
	for (genvar c = 0; c < MAX_POINTS; c++) begin : g_cell
		if (c == MAX_POINTS - 1) begin : g_tail
			assign nxt_coef[c] = load_tail ? item.coefficient : cell_coef[0];
			assign nxt_len[c]  = load_tail ? ec_inc : cell_len[0];
			assign nxt_sum[c]  = load_tail ? 40'sd0 : cell_sum[0] + add_val;
		end else begin : g_link
			assign nxt_coef[c] = cell_coef[c+1];
			assign nxt_len[c]  = cell_len[c+1];
			assign nxt_sum[c]  = cell_sum[c+1];
		end
		gks_cell #(
			.LEN_W(LW)
		) u_cell (
			.clk,
			.ctrl      (ring_ctrl),
			.next_coef (nxt_coef[c]),
			.next_len  (nxt_len[c]),
			.next_sum  (nxt_sum[c]),
			.coef      (cell_coef[c]),
			.len       (cell_len[c]),
			.sum       (cell_sum[c])
		);
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

@@ design/gks_ram.sv @@
`default_nettype none
module gks_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr_a,
	output logic      [WIDTH-1:0]  rd_data_a,
	input  wire logic [ADDR_W-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]  rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule
`default_nettype wire

@@ design/gks_cell.sv @@
`default_nettype none
module gks_cell #(
	parameter int LEN_W = 7
) (
	input  wire logic                    clk,
	input  wire gks_pkg::cell_ctrl_t     ctrl,
	input  wire logic signed [15:0]      next_coef,
	input  wire logic        [LEN_W-1:0] next_len,
	input  wire logic signed [39:0]      next_sum,
	output logic signed      [15:0]      coef,
	output logic             [LEN_W-1:0] len,
	output logic signed      [39:0]      sum
);

	import gks_pkg::*;

	logic signed [15:0]      coef_q;
	logic        [LEN_W-1:0] len_q;
	logic signed [39:0]      sum_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			coef_q <= next_coef;
			len_q  <= next_len;
		end
		if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.shift) begin
			sum_q <= next_sum;
		end
	end

	assign coef = coef_q;
	assign len  = len_q;
	assign sum  = sum_q;

endmodule
`default_nettype wire

@@ design/gks_kernel.sv @@
`default_nettype none
module gks_kernel #(
	parameter int R_W = 40
) (
	input  wire logic           clk,
	input  wire logic [R_W-1:0] r2,
	output logic      [15:0]    k
);

	import gks_pkg::*;

	logic [R_W-16:0] a16;
	logic [19:0]     a20;
	logic [36:0]     t;
	logic            zero_s3;
	logic [4:0]      ip_s3;
	logic [15:0]     fr_s3;

	logic [16:0] hi;
	logic [16:0] lo;
	logic [28:0] slope;
	logic [16:0] v;
	logic        zero_s4;
	logic [4:0]  ip_s4;
	logic [16:0] v_s4;

	logic [16:0] sh;
	logic [15:0] k_s5;

	// argument r2/2 in Q.16, scaled by log2(e)
	assign a16 = r2[R_W-1:15];
	assign a20 = 20'(a16);
	assign t   = 37'(a20) * 37'(LOG2E_Q16);

	always_ff @(posedge clk) begin
		zero_s3 <= (a16 >= ARG_LIMIT);
		ip_s3   <= t[36:32];
		fr_s3   <= t[31:16];
	end

	// linear interpolation between table points
	assign hi    = pow2_neg({1'b0, fr_s3[15:12]});
	assign lo    = pow2_neg(5'({1'b0, fr_s3[15:12]}) + 5'd1);
	assign slope = 29'(hi - lo) * 29'(fr_s3[11:0]);
	assign v     = hi - 17'(slope >> 12);

	always_ff @(posedge clk) begin
		zero_s4 <= zero_s3 || (ip_s3 > 5'd16);
		ip_s4   <= ip_s3;
		v_s4    <= v;
	end

	assign sh = v_s4 >> ip_s4;

	always_ff @(posedge clk) begin
		if (zero_s4) begin
			k_s5 <= '0;
		end else if (sh > K_SAT) begin
			k_s5 <= K_SAT[15:0];
		end else begin
			k_s5 <= sh[15:0];
		end
	end

	assign k = k_s5;

endmodule
`default_nettype wire

@@ design/gks_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module gks_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire gks_pkg::item_t     item,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire gks_pkg::result_t   result
);

	import gks_pkg::*;

	logic [5:0] exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (result_valid && !result_stall) begin
			exp_idx_q <= result.last ? 6'd0 : 6'(exp_idx_q + 1'b1);
		end
	end

	`CHECK_NEXT(a_valid_held, clk, arst_n, result_valid && result_stall, result_valid)
	`CHECK_NEXT(a_data_held, clk, arst_n, result_valid && result_stall, $stable(result))
	`CHECK_NOW(a_index_order, clk, arst_n, result_valid, result.point_index == exp_idx_q)
	`CHECK_NEXT(a_busy_after_set, clk, arst_n, item_valid && !item_stall && item.last_of_set, item_stall)

endmodule

bind gaussian_kernel_sum gks_checker u_checker (.*);
`default_nettype wire

@@ tb/kernel_sum_checker.sv @@
`timescale 1ns / 100ps
module kernel_sum_checker
	import gks_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	input  wire logic    item_stall,
	input  wire item_t   item,
	input  wire logic    result_valid,
	input  wire logic    result_stall,
	input  wire result_t result,
	output int           failures,
	output int           pending
);

	localparam int POINTS = 64;
	localparam int DIM    = 100;

	// 2^(-k/16) in Q.16
	localparam longint EXP2_TAB [17] = '{
		65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
		46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
	};

	logic signed [15:0] feat [POINTS][DIM];
	logic signed [15:0] coef [POINTS];
	int                 point_cnt;
	int                 elem_cnt;
	bit                 dropped;
	result_t            sums_due [$];

	assign pending = sums_due.size();

	function automatic longint gauss(input longint r2);
		longint a16, t, ip, fr, hi, lo, v;
		a16 = r2 >> 15;
		if (a16 >= 786432)
			return 0;
		t = (a16 * 94548) >> 16;
		ip = t >> 16;
		if (ip > 16)
			return 0;
		fr = t & 65535;
		hi = EXP2_TAB[fr >> 12];
		lo = EXP2_TAB[(fr >> 12) + 1];
		v = hi - (((hi - lo) * (fr & 4095)) >> 12);
		v = v >> ip;
		return (v > 65535) ? 65535 : v;
	endfunction

	task automatic take_item(input item_t it);
		bit full, end_pt;
		longint acc [POINTS];
		longint r2, k, d;
		result_t r;
		full = point_cnt >= POINTS;
		end_pt = it.last_of_point || it.last_of_set;
		if (!full && elem_cnt < DIM)
			feat[point_cnt][elem_cnt] = it.feature;
		if (elem_cnt < DIM)
			elem_cnt++;
		if (end_pt) begin
			if (full) begin
				dropped = 1;
			end else begin
				for (int e = elem_cnt; e < DIM; e++)
					feat[point_cnt][e] = '0;
				coef[point_cnt] = it.coefficient;
				point_cnt++;
			end
			elem_cnt = 0;
		end
		if (!it.last_of_set)
			return;
		for (int i = 0; i < point_cnt; i++)
			acc[i] = longint'(coef[i]) * 2;
		for (int i = 0; i < point_cnt; i++) begin
			for (int j = 0; j < i; j++) begin
				r2 = 0;
				for (int e = 0; e < DIM; e++) begin
					d = longint'(feat[i][e]) - longint'(feat[j][e]);
					r2 += d * d;
				end
				k = gauss(r2);
				acc[i] += (k * longint'(coef[j])) >>> 15;
				acc[j] += (k * longint'(coef[i])) >>> 15;
			end
		end
		for (int i = 0; i < point_cnt; i++) begin
			r.kernel_sum = acc[i][39:0];
			r.point_index = i[5:0];
			r.last = (i + 1 == point_cnt);
			r.overflow = dropped;
			sums_due.push_back(r);
		end
		point_cnt = 0;
		elem_cnt = 0;
		dropped = 0;
	endtask

	task automatic compare_sum(input result_t got);
		result_t want;
		if (sums_due.size() == 0) begin
			$error("unexpected result transfer, index %0d", got.point_index);
			failures++;
			return;
		end
		want = sums_due.pop_front();
		if (got.kernel_sum !== want.kernel_sum) begin
			$error("kernel_sum expected %0d actual %0d", want.kernel_sum, got.kernel_sum);
			failures++;
		end
		if (got.point_index !== want.point_index) begin
			$error("point_index expected %0d actual %0d", want.point_index, got.point_index);
			failures++;
		end
		if (got.last !== want.last) begin
			$error("last expected %0b actual %0b", want.last, got.last);
			failures++;
		end
		if (got.overflow !== want.overflow) begin
			$error("overflow expected %0b actual %0b", want.overflow, got.overflow);
			failures++;
		end
	endtask

	initial begin
		failures = 0;
		point_cnt = 0;
		elem_cnt = 0;
		dropped = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				compare_sum(result);
			if (item_valid && !item_stall)
				take_item(item);
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
	import gks_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	int      failures;
	int      pending;

	bit                 calm = 0;
	bit                 hold_req = 0;
	bit                 hold_done = 0;
	int                 hold_cnt = 0;
	logic signed [15:0] base [100];

	always #10 clk = ~clk;

	gaussian_kernel_sum dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	kernel_sum_checker chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.failures(failures), .pending(pending)
	);

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1;
			hold_cnt = 2000;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(99) < 32);
		end
	end

	task automatic send(input logic [15:0] f, input logic [15:0] c, input bit lp,
			input bit ls);
		item_t it;
		it.feature = f;
		it.coefficient = c;
		it.last_of_point = lp;
		it.last_of_set = ls;
		while (!calm && $urandom_range(99) < 32) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic fresh_base();
		for (int d = 0; d < 100; d++)
			base[d] = 16'($urandom);
	endtask

	// one point near the shared base, spread sets how far
	task automatic send_point(input int elems, input int spread, input bit ls);
		int          n;
		logic [15:0] c;
		bit          lp;
		c = 16'($urandom);
		for (int e = 0; e < elems; e++) begin
			n = (spread == 0) ? 0 : int'($urandom_range(0, 2 * spread)) - spread;
			lp = (e == elems - 1) && (!ls || $urandom_range(1));
			send(16'(base[e % 100] + n), c, lp, ls && (e == elems - 1));
		end
	endtask

	initial begin
		int np, spread;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, identical points, set end without point end
		send(16'h7fff, 16'h7fff, 1, 1);
		send(16'h8000, 16'h8000, 1, 0);
		send(16'h8000, 16'h8000, 1, 1);
		send(16'h0000, 16'h7fff, 0, 0);
		send(16'h0001, 16'h7fff, 1, 0);
		send(16'h0000, 16'h8000, 0, 0);
		send(16'h0000, 16'h8000, 0, 1);
		send(16'h7fff, 16'h1234, 1, 0);
		send(16'h8000, 16'hedcb, 1, 0);
		send(16'h0100, 16'h4000, 0, 0);
		send(16'h0100, 16'h4000, 1, 0);
		send(16'h0180, 16'hc000, 1, 1);

		for (int s = 0; s < 18; s++) begin
			if (s == 6)
				hold_req = 1;
			calm = (s >= 10 && s < 13);
			fresh_base();
			case ($urandom_range(3))
				0: spread = 0;
				1: spread = 64;
				2: spread = 2048;
				default: spread = 32767;
			endcase
			if (s == 11) begin
				// more points than the block can hold
				for (int p = 0; p < 66; p++)
					send_point(1, 32767, p == 65);
			end else begin
				np = $urandom_range(1, 3);
				for (int p = 0; p < np; p++)
					send_point($urandom_range(1, 2), spread, p == np - 1);
			end
		end
		calm = 0;
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#40000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
